// ----- design/trm_pkg.sv -----
// Package for the toy register machine step block.
// Holds transaction types, opcodes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package trm_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NREGS     = 32;
	localparam int RF_AW     = $clog2(NREGS);
	localparam int IBYTES    = 6;
	localparam logic [15:0] INSN_LEN = 16'd8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] mem_addr;
		logic [7:0]  mem_data;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_byte;
		logic [15:0] next_pc;
		logic        halted;
		logic        fault;
	} result_t;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_EXEC  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [7:0] {
		OP_ADD   = 8'd1,
		OP_SUB   = 8'd2,
		OP_MUL   = 8'd3,
		OP_DIV   = 8'd4,
		OP_LOAD  = 8'd5,
		OP_STORE = 8'd6,
		OP_AND   = 8'd7,
		OP_OR    = 8'd8,
		OP_XOR   = 8'd9,
		OP_NOR   = 8'd10,
		OP_SLT   = 8'd11,
		OP_SAR   = 8'd12,
		OP_SHL   = 8'd13,
		OP_BEQ   = 8'd14,
		OP_JMP   = 8'd15,
		OP_HLT   = 8'd16
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISP, ST_MEMRD, ST_FETCH, ST_RDA, ST_RDB, ST_RDC,
		ST_OP, ST_DIVW, ST_LOAD, ST_LWB, ST_STORE, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ASEL_IN, ASEL_PC, ASEL_WORD
	} asel_t;

	typedef enum logic [1:0] {
		WSEL_ALU, WSEL_DIV, WSEL_LOAD
	} wsel_t;

	typedef struct packed {
		logic       load_in;
		logic       mem_we;
		logic       mem_re;
		logic       mem_wsrc_reg;
		asel_t      asel;
		logic [2:0] cnt;
		logic       cap_ib;
		logic       cap_wd;
		logic       cap_rb;
		logic       rf_re;
		logic       rf_rsel_b;
		logic       cap_a;
		logic       cap_b;
		logic       rf_we;
		wsel_t      wsel;
		logic       div_start;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       stopped;
		logic [7:0] op;
		logic       div_done;
	} status_t;

endpackage

// ----- design/trm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module trm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/trm_div.sv -----
// Iterative signed 32-bit divider, one quotient bit per cycle; divide by zero gives 0.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
module trm_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);

	logic [31:0] rem_q, quo_q, ub_q;
	logic        neg_q, zero_q, run_q, done_q;
	logic [5:0]  cnt_q;
	logic [32:0] shifted, trial;

	assign shifted = {rem_q, quo_q[31]};
	assign trial   = shifted - {1'b0, ub_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q  <= dividend[31] ? (32'd0 - dividend) : dividend;
			ub_q   <= divisor[31] ? (32'd0 - divisor) : divisor;
			rem_q  <= '0;
			neg_q  <= dividend[31] ^ divisor[31];
			zero_q <= (divisor == 32'd0);
		end else if (run_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = zero_q ? 32'd0 : (neg_q ? (32'd0 - quo_q) : quo_q);

endmodule

// ----- design/trm_datapath.sv -----
// Datapath of the toy register machine: memories, register file, ALU, divider, pc and flags.
// Depends on trm_pkg, trm_ram and trm_div.
`timescale 1ns / 1ps
module trm_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  trm_pkg::item_t  item,
	input  trm_pkg::cmd_t   cmd,
	output trm_pkg::status_t status,
	output trm_pkg::result_t result
);

	trm_pkg::item_t in_q;
	logic [7:0]  ib_q [trm_pkg::IBYTES];
	logic [7:0]  wd_q [4];
	logic [31:0] a_q, b_q;
	logic [15:0] pc_q;
	logic        stopped_q, fault_q;
	logic [7:0]  rb_q;
	logic [trm_pkg::NREGS-1:0] rf_vld_q;
	logic        rf_vld_rd_q;

	logic [31:0] word_addr, rf_rdata, rf_val, alu, rf_wdata, div_q, mem_wdata_w;
	logic [15:0] mem_addr16;
	logic [7:0]  mem_rdata, mem_wdata;
	logic [3:0]  s1, s2;
	logic [4:0]  dst, rn;
	logic [trm_pkg::RF_AW-1:0] rf_raddr, rf_waddr;
	logic [2:0]  cap_idx;
	logic        is_mem_op, div_done;

	assign s1        = ib_q[1][3:0];
	assign s2        = ib_q[1][7:4];
	assign dst       = ib_q[2][4:0];
	assign rn        = ib_q[1][4:0];
	assign word_addr = {ib_q[5], ib_q[4], ib_q[3], ib_q[2]};
	assign is_mem_op = (ib_q[0] == trm_pkg::OP_LOAD) || (ib_q[0] == trm_pkg::OP_STORE);
	assign cap_idx   = cmd.cnt - 3'd1;

	always_comb begin
		unique case (cmd.asel)
			trm_pkg::ASEL_PC:   mem_addr16 = pc_q + {13'd0, cmd.cnt};
			trm_pkg::ASEL_WORD: mem_addr16 = word_addr[15:0] + {13'd0, cmd.cnt};
			default:            mem_addr16 = in_q.mem_addr;
		endcase
	end

	assign mem_wdata_w = a_q >> {cmd.cnt[1:0], 3'd0};
	assign mem_wdata   = cmd.mem_wsrc_reg ? mem_wdata_w[7:0] : in_q.mem_data;

	trm_ram #(.WIDTH(8), .DEPTH(trm_pkg::MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (cmd.mem_we),
		.waddr (mem_addr16[trm_pkg::MEM_AW-1:0]),
		.wdata (mem_wdata),
		.re    (cmd.mem_re),
		.raddr (mem_addr16[trm_pkg::MEM_AW-1:0]),
		.rdata (mem_rdata)
	);

	assign rf_raddr = cmd.rf_rsel_b ? {1'b0, s2} : (is_mem_op ? rn : {1'b0, s1});
	assign rf_waddr = (cmd.wsel == trm_pkg::WSEL_LOAD) ? rn : dst;

	always_comb begin
		unique case (cmd.wsel)
			trm_pkg::WSEL_DIV:  rf_wdata = div_q;
			trm_pkg::WSEL_LOAD: rf_wdata = {wd_q[3], wd_q[2], wd_q[1], wd_q[0]};
			default:            rf_wdata = alu;
		endcase
	end

	trm_ram #(.WIDTH(32), .DEPTH(trm_pkg::NREGS)) u_rf (
		.clk   (clk),
		.we    (cmd.rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (cmd.rf_re),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	// Registers never written since reset read as zero.
	assign rf_val = rf_vld_rd_q ? rf_rdata : 32'd0;

	always_comb begin
		unique case (ib_q[0])
			trm_pkg::OP_ADD: alu = a_q + b_q;
			trm_pkg::OP_SUB: alu = a_q - b_q;
			trm_pkg::OP_MUL: alu = a_q * b_q;
			trm_pkg::OP_AND: alu = a_q & b_q;
			trm_pkg::OP_OR:  alu = a_q | b_q;
			trm_pkg::OP_XOR: alu = a_q ^ b_q;
			trm_pkg::OP_NOR: alu = ~(a_q | b_q);
			trm_pkg::OP_SLT: alu = {31'd0, ($signed(a_q) < $signed(b_q))};
			trm_pkg::OP_SAR: alu = $unsigned($signed(a_q) >>> b_q[4:0]);
			trm_pkg::OP_SHL: alu = a_q << b_q[4:0];
			default:         alu = 32'd0;
		endcase
	end

	trm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_q),
		.divisor  (b_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			stopped_q   <= 1'b0;
			fault_q     <= 1'b0;
			rf_vld_q    <= '0;
			rf_vld_rd_q <= 1'b0;
		end else begin
			if (cmd.rf_re) begin
				rf_vld_rd_q <= rf_vld_q[rf_raddr];
			end
			if (cmd.rf_we) begin
				rf_vld_q[rf_waddr] <= 1'b1;
			end
			if (cmd.finish) begin
				unique case (ib_q[0])
					trm_pkg::OP_ADD, trm_pkg::OP_SUB, trm_pkg::OP_MUL, trm_pkg::OP_DIV,
					trm_pkg::OP_LOAD, trm_pkg::OP_STORE, trm_pkg::OP_AND, trm_pkg::OP_OR,
					trm_pkg::OP_XOR, trm_pkg::OP_NOR, trm_pkg::OP_SLT, trm_pkg::OP_SAR,
					trm_pkg::OP_SHL: pc_q <= pc_q + trm_pkg::INSN_LEN;
					trm_pkg::OP_BEQ: begin
						pc_q <= (a_q == b_q) ? (word_addr[15:0] + trm_pkg::INSN_LEN)
						                     : (pc_q + trm_pkg::INSN_LEN);
					end
					trm_pkg::OP_JMP: pc_q <= word_addr[15:0];
					trm_pkg::OP_HLT: stopped_q <= 1'b1;
					default: begin
						stopped_q <= 1'b1;
						fault_q   <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= item;
			rb_q <= 8'd0;
		end
		if (cmd.cap_rb) begin
			rb_q <= mem_rdata;
		end
		if (cmd.cap_ib) begin
			ib_q[cap_idx] <= mem_rdata;
		end
		if (cmd.cap_wd) begin
			wd_q[cap_idx[1:0]] <= mem_rdata;
		end
		if (cmd.cap_a) begin
			a_q <= rf_val;
		end
		if (cmd.cap_b) begin
			b_q <= rf_val;
		end
	end

	assign status.mode     = in_q.mode;
	assign status.stopped  = stopped_q;
	assign status.op       = ib_q[0];
	assign status.div_done = div_done;

	assign result.read_byte = rb_q;
	assign result.next_pc   = pc_q;
	assign result.halted    = stopped_q;
	assign result.fault     = fault_q;

endmodule

// ----- design/trm_ctrl.sv -----
// Controller state machine of the toy register machine; sequences the datapath.
// Depends on trm_pkg.
`timescale 1ns / 1ps
module trm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  trm_pkg::status_t status,
	output trm_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	trm_pkg::state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= trm_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			trm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load_in = 1'b1;
					state_d     = trm_pkg::ST_DISP;
				end
			end
			trm_pkg::ST_DISP: begin
				cnt_d = '0;
				priority if (status.mode == trm_pkg::MODE_WRITE) begin
					cmd.mem_we = 1'b1;
					state_d    = trm_pkg::ST_DONE;
				end else if (status.mode == trm_pkg::MODE_READ) begin
					cmd.mem_re = 1'b1;
					state_d    = trm_pkg::ST_MEMRD;
				end else if (status.mode == trm_pkg::MODE_EXEC && !status.stopped) begin
					state_d = trm_pkg::ST_FETCH;
				end else begin
					state_d = trm_pkg::ST_DONE;
				end
			end
			trm_pkg::ST_MEMRD: begin
				cmd.cap_rb = 1'b1;
				state_d    = trm_pkg::ST_DONE;
			end
			trm_pkg::ST_FETCH: begin
				// Reads are issued one byte ahead of their capture.
				cmd.asel   = trm_pkg::ASEL_PC;
				cmd.mem_re = (cnt_q != 3'(trm_pkg::IBYTES));
				cmd.cap_ib = (cnt_q != 3'd0);
				if (cnt_q == 3'(trm_pkg::IBYTES)) begin
					cnt_d   = '0;
					state_d = trm_pkg::ST_RDA;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			trm_pkg::ST_RDA: begin
				cmd.rf_re = 1'b1;
				state_d   = trm_pkg::ST_RDB;
			end
			trm_pkg::ST_RDB: begin
				cmd.cap_a     = 1'b1;
				cmd.rf_re     = 1'b1;
				cmd.rf_rsel_b = 1'b1;
				state_d       = trm_pkg::ST_RDC;
			end
			trm_pkg::ST_RDC: begin
				cmd.cap_b = 1'b1;
				state_d   = trm_pkg::ST_OP;
			end
			trm_pkg::ST_OP: begin
				cnt_d = '0;
				unique case (status.op)
					trm_pkg::OP_ADD, trm_pkg::OP_SUB, trm_pkg::OP_MUL, trm_pkg::OP_AND,
					trm_pkg::OP_OR, trm_pkg::OP_XOR, trm_pkg::OP_NOR, trm_pkg::OP_SLT,
					trm_pkg::OP_SAR, trm_pkg::OP_SHL: begin
						cmd.rf_we  = 1'b1;
						cmd.wsel   = trm_pkg::WSEL_ALU;
						cmd.finish = 1'b1;
						state_d    = trm_pkg::ST_DONE;
					end
					trm_pkg::OP_DIV: begin
						cmd.div_start = 1'b1;
						state_d       = trm_pkg::ST_DIVW;
					end
					trm_pkg::OP_LOAD:  state_d = trm_pkg::ST_LOAD;
					trm_pkg::OP_STORE: state_d = trm_pkg::ST_STORE;
					default: begin
						cmd.finish = 1'b1;
						state_d    = trm_pkg::ST_DONE;
					end
				endcase
			end
			trm_pkg::ST_DIVW: begin
				if (status.div_done) begin
					cmd.rf_we  = 1'b1;
					cmd.wsel   = trm_pkg::WSEL_DIV;
					cmd.finish = 1'b1;
					state_d    = trm_pkg::ST_DONE;
				end
			end
			trm_pkg::ST_LOAD: begin
				cmd.asel   = trm_pkg::ASEL_WORD;
				cmd.mem_re = (cnt_q != 3'd4);
				cmd.cap_wd = (cnt_q != 3'd0);
				if (cnt_q == 3'd4) begin
					state_d = trm_pkg::ST_LWB;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			trm_pkg::ST_LWB: begin
				cmd.rf_we  = 1'b1;
				cmd.wsel   = trm_pkg::WSEL_LOAD;
				cmd.finish = 1'b1;
				state_d    = trm_pkg::ST_DONE;
			end
			trm_pkg::ST_STORE: begin
				cmd.asel         = trm_pkg::ASEL_WORD;
				cmd.mem_we       = 1'b1;
				cmd.mem_wsrc_reg = 1'b1;
				if (cnt_q == 3'd3) begin
					cmd.finish = 1'b1;
					state_d    = trm_pkg::ST_DONE;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			trm_pkg::ST_DONE: begin
				done    = 1'b1;
				state_d = trm_pkg::ST_IDLE;
			end
			default: state_d = trm_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- design/toy_register_machine_step.sv -----
// Toy register machine, one transaction per step: byte write, byte read or one instruction.
// A divide is the longest transaction, as the divider produces its quotient one bit at a time;
// the byte-wide memory port lengthens fetch, load and store. A new transaction is taken only
// once the previous one has ended and busy is low.
// Reset clears pc, flags and register file; memory contents stay undefined until written.
`timescale 1ns / 1ps
module toy_register_machine_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  trm_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output trm_pkg::result_t result
);

	// The controller only issues commands; all storage and arithmetic sit in the datapath.
	trm_pkg::cmd_t    cmd;
	trm_pkg::status_t status;

	trm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The result registers are held from the end of a transaction, so the
	// done strobe marks a stable value for its single cycle.
	trm_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

// ----- design/trm_checker.sv -----
// Port-level checker for the toy register machine step block, bound to the top level.
// Depends on trm_pkg.
`timescale 1ns / 1ps
module trm_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input trm_pkg::result_t result
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done strobe outside a transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted transaction did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done strobe longer than one cycle");

	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.fault) |-> result.halted)
		else $error("fault reported without halt");

endmodule

bind toy_register_machine_step trm_checker u_trm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- sim/toy_register_machine_step_test.sv -----
// Testbench for toy_register_machine_step: directed memory and instruction tables, then random
// instruction streams, checked against listed results (memory rows) or a behavioral model here.
// Depends on design/trm_pkg.sv and design/toy_register_machine_step.sv.
`timescale 1ns / 1ps
module toy_register_machine_step_test;
	import trm_pkg::*;

	localparam int RUN_LIMIT = 1000000;
	localparam int N_ITEMS   = 1250;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    done;
	result_t result;

	toy_register_machine_step dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Machine image used to predict each transaction. Memory bytes that were never written
	// are tracked so that no transaction ever reads one.
	logic [7:0]  mem_img [MEM_BYTES];
	bit          mem_seen [MEM_BYTES];
	int          seen_addrs [$];
	logic [31:0] regs_m [NREGS];
	logic [15:0] pc_m = '0;
	bit          stop_m = 1'b0;
	bit          flt_m = 1'b0;

	result_t     expected_results [$];
	int          fails = 0;
	int          n_sent = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	function automatic logic [31:0] word_at(input logic [15:0] a);
		return {mem_img[16'(a + 3)], mem_img[16'(a + 2)], mem_img[16'(a + 1)], mem_img[a]};
	endfunction

	function automatic void poke(input logic [15:0] a, input logic [7:0] v);
		if (!mem_seen[a])
			seen_addrs.push_back(a);
		mem_seen[a] = 1'b1;
		mem_img[a] = v;
	endfunction

	// Executes one instruction at pc_m on the image.
	function automatic void run_insn();
		logic [7:0]  op, b1;
		logic [31:0] a, b, tgt, res;
		logic [4:0]  dst, rn, sh;
		logic [15:0] nxt;
		bit          wr;
		op  = mem_img[pc_m];
		b1  = mem_img[16'(pc_m + 1)];
		dst = mem_img[16'(pc_m + 2)][4:0];
		rn  = b1[4:0];
		tgt = word_at(16'(pc_m + 2));
		a   = regs_m[b1[3:0]];
		b   = regs_m[b1[7:4]];
		sh  = b[4:0];
		nxt = 16'(pc_m + INSN_LEN);
		wr  = 1'b1;
		res = '0;
		case (op)
			OP_ADD: res = a + b;
			OP_SUB: res = a - b;
			OP_MUL: res = a * b;
			OP_DIV: begin
				if (b == 0)
					res = '0;
				else if (a == 32'h8000_0000 && b == 32'hffff_ffff)
					res = a;
				else
					res = $signed(a) / $signed(b);
			end
			OP_AND: res = a & b;
			OP_OR:  res = a | b;
			OP_XOR: res = a ^ b;
			OP_NOR: res = ~(a | b);
			OP_SLT: res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			OP_SAR: res = $signed(a) >>> sh;
			OP_SHL: res = a << sh;
			OP_LOAD: begin
				wr = 1'b0;
				regs_m[rn] = word_at(tgt[15:0]);
			end
			OP_STORE: begin
				wr = 1'b0;
				for (int k = 0; k < 4; k++)
					poke(16'(tgt[15:0] + k), regs_m[rn][8*k +: 8]);
			end
			OP_BEQ: begin
				wr = 1'b0;
				if (a == b)
					nxt = 16'(tgt[15:0] + INSN_LEN);
			end
			OP_JMP: begin
				wr = 1'b0;
				nxt = tgt[15:0];
			end
			OP_HLT: begin
				wr = 1'b0;
				stop_m = 1'b1;
				nxt = pc_m;
			end
			default: begin
				wr = 1'b0;
				stop_m = 1'b1;
				flt_m = 1'b1;
				nxt = pc_m;
			end
		endcase
		if (wr)
			regs_m[dst] = res;
		pc_m = nxt;
	endfunction

	function automatic result_t machine_step(input item_t it);
		result_t r;
		r = '0;
		case (mode_t'(it.mode))
			MODE_WRITE: poke(it.mem_addr, it.mem_data);
			MODE_READ:  r.read_byte = mem_img[it.mem_addr];
			MODE_EXEC:  if (!stop_m) run_insn();
			default: ;
		endcase
		r.next_pc = pc_m;
		r.halted  = stop_m;
		r.fault   = flt_m;
		return r;
	endfunction

	// Drives one transaction. Start is lowered only when a gap is taken, so a back-to-back
	// transaction never lowers and raises start within one time step.
	task automatic send(input item_t it, input bit typed = 1'b0, input result_t want = '0);
		result_t r;
		if (!quiet && $urandom_range(99) < 33) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 33);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		r = machine_step(it);
		expected_results.push_back(typed ? want : r);
		n_sent++;
	endtask

	task automatic put_byte(input logic [15:0] a, input logic [7:0] v);
		item_t it;
		it = '{mode: MODE_WRITE, mem_addr: a, mem_data: v};
		send(it);
	endtask

	task automatic put_insn(input logic [7:0] op, input logic [7:0] b1, input logic [7:0] b2,
			input logic [31:0] tgt);
		logic [47:0] bytes;
		bytes = {tgt[31:16], tgt[15:8], tgt[7:0], b1, op};
		// Byte 2 doubles as the destination and the low target byte, as in the encoding.
		bytes[23:16] = (op == OP_LOAD || op == OP_STORE || op == OP_BEQ || op == OP_JMP)
			? tgt[7:0] : b2;
		for (int k = 0; k < IBYTES; k++)
			put_byte(16'(pc_m + k), bytes[8*k +: 8]);
	endtask

	function automatic logic [7:0] pick_op();
		if ($urandom_range(3) == 0)
			return OP_LOAD;
		return 8'($urandom_range(OP_ADD, OP_JMP));
	endfunction

	function automatic logic [31:0] pick_target();
		logic [31:0] t;
		t = $urandom();
		if ($urandom_range(1))
			t[15:0] = 16'h1000 + 16'($urandom_range(255));
		return t;
	endfunction

	// Executes at the current pc. Unwritten fetch bytes, a stopping opcode that is not wanted yet,
	// or a set fresh flag bring in a fresh random instruction; a load gets its data written.
	task automatic exec_at_pc(input bit allow_stop, input bit fresh);
		item_t       it;
		bit          bad;
		logic [7:0]  op;
		logic [31:0] tgt;
		if (!stop_m) begin
			bad = fresh;
			for (int k = 0; k < IBYTES; k++)
				if (!mem_seen[16'(pc_m + k)])
					bad = 1'b1;
			op = mem_img[pc_m];
			if (!allow_stop && (op < OP_ADD || op > OP_JMP))
				bad = 1'b1;
			if (bad)
				put_insn(pick_op(), 8'($urandom()), 8'($urandom()), pick_target());
			if (mem_img[pc_m] == OP_LOAD) begin
				tgt = word_at(16'(pc_m + 2));
				for (int k = 0; k < 4; k++)
					if (!mem_seen[16'(tgt[15:0] + k)])
						put_byte(16'(tgt[15:0] + k), 8'($urandom()));
			end
		end
		it = '{mode: MODE_EXEC, mem_addr: 16'($urandom()), mem_data: 8'($urandom())};
		send(it);
	endtask

	// Each transaction result is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t w;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result %p", result);
				fails++;
			end else begin
				w = expected_results.pop_front();
				if (result.read_byte !== w.read_byte) begin
					$error("read_byte: expected %h, got %h", w.read_byte, result.read_byte);
					fails++;
				end
				if (result.next_pc !== w.next_pc) begin
					$error("next_pc: expected %h, got %h", w.next_pc, result.next_pc);
					fails++;
				end
				if (result.halted !== w.halted) begin
					$error("halted: expected %b, got %b", w.halted, result.halted);
					fails++;
				end
				if (result.fault !== w.fault) begin
					$error("fault: expected %b, got %b", w.fault, result.fault);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	typedef struct {
		item_t   it;
		result_t want;
	} mem_row_t;

	typedef struct {
		logic [7:0]  op;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [31:0] tgt;
		logic [31:0] data;
	} insn_row_t;

	// Memory rows run from reset, so pc and flags are still zero and each result is known.
	mem_row_t mem_rows [] = '{
		'{'{MODE_WRITE, 16'h0000, 8'hff}, '{8'h00, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_READ,  16'h0000, 8'h00}, '{8'hff, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_WRITE, 16'hffff, 8'h00}, '{8'h00, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_READ,  16'hffff, 8'hff}, '{8'h00, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_WRITE, 16'h8000, 8'h5a}, '{8'h00, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_READ,  16'h8000, 8'ha5}, '{8'h5a, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_WRITE, 16'h7fff, 8'ha5}, '{8'h00, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_READ,  16'h7fff, 8'h5a}, '{8'ha5, 16'h0000, 1'b0, 1'b0}},
		'{'{MODE_NONE,  16'hffff, 8'hff}, '{8'h00, 16'h0000, 1'b0, 1'b0}}
	};

	// Instruction rows: operands first (most negative, minus one, most positive), then every
	// operation but halt, with the wrapping divide, divide by zero, full-width shifts, a store and
	// load that wrap the address space, both branch outcomes and a jump whose fetch wraps.
	insn_row_t insn_rows [] = '{
		'{OP_LOAD,  8'h01, 8'h00, 32'h0000_1000, 32'h8000_0000},
		'{OP_LOAD,  8'he2, 8'h00, 32'hffff_1004, 32'hffff_ffff},
		'{OP_LOAD,  8'h03, 8'h00, 32'h0000_1008, 32'h7fff_ffff},
		'{OP_DIV,   8'h21, 8'h04, 32'h0,         32'h0},
		'{OP_DIV,   8'h01, 8'h05, 32'h0,         32'h0},
		'{OP_DIV,   8'h13, 8'h06, 32'h0,         32'h0},
		'{OP_ADD,   8'h31, 8'h07, 32'h0,         32'h0},
		'{OP_SUB,   8'h21, 8'h08, 32'h0,         32'h0},
		'{OP_MUL,   8'h33, 8'h09, 32'h0,         32'h0},
		'{OP_AND,   8'h21, 8'h0a, 32'h0,         32'h0},
		'{OP_OR,    8'h31, 8'h0b, 32'h0,         32'h0},
		'{OP_XOR,   8'h23, 8'h0c, 32'h0,         32'h0},
		'{OP_NOR,   8'h10, 8'hff, 32'h0,         32'h0},
		'{OP_SLT,   8'h31, 8'he0, 32'h0,         32'h0},
		'{OP_SLT,   8'h13, 8'h0d, 32'h0,         32'h0},
		'{OP_SAR,   8'h21, 8'h0e, 32'h0,         32'h0},
		'{OP_SHL,   8'h23, 8'h0f, 32'h0,         32'h0},
		'{OP_STORE, 8'h01, 8'h00, 32'hdead_fffe, 32'h0},
		'{OP_LOAD,  8'h10, 8'h00, 32'h0000_fffe, 32'h0},
		'{OP_BEQ,   8'h21, 8'h00, 32'h0000_3000, 32'h0},
		'{OP_BEQ,   8'h00, 8'h00, 32'h0000_2000, 32'h0},
		'{OP_JMP,   8'h00, 8'h00, 32'habcd_fffc, 32'h0},
		'{OP_ADD,   8'h12, 8'h11, 32'h0,         32'h0}
	};

	initial begin
		item_t   it;
		int      pick;
		for (int k = 0; k < NREGS; k++)
			regs_m[k] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (mem_rows[k])
			send(mem_rows[k].it, 1'b1, mem_rows[k].want);
		foreach (insn_rows[k]) begin
			if (insn_rows[k].op == OP_LOAD && insn_rows[k].data != 0)
				for (int j = 0; j < 4; j++)
					put_byte(16'(insn_rows[k].tgt[15:0] + j), insn_rows[k].data[8*j +: 8]);
			put_insn(insn_rows[k].op, insn_rows[k].b1, insn_rows[k].b2, insn_rows[k].tgt);
			exec_at_pc(1'b0, 1'b0);
		end

		// Random part: mostly instruction streams, with byte traffic and unused-mode noise.
		for (int i = 0; n_sent < N_ITEMS; i++) begin
			quiet = (i >= 300 && i < 450);
			if (i == 700) begin
				// Let the block drain completely once before going on; start is dropped so
				// the last transaction is not taken a second time.
				start <= 1'b0;
				while (expected_results.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 10) begin
				it = '{mode: MODE_WRITE, mem_addr: 16'($urandom()), mem_data: 8'($urandom())};
				send(it);
			end else if (pick < 16) begin
				it = '{mode: MODE_READ,
					mem_addr: 16'(seen_addrs[$urandom_range(seen_addrs.size() - 1)]),
					mem_data: 8'($urandom())};
				send(it);
			end else if (pick < 18) begin
				it = '{mode: MODE_NONE, mem_addr: 16'($urandom()), mem_data: 8'($urandom())};
				send(it);
			end else begin
				exec_at_pc(1'b0, $urandom_range(1));
			end
		end
		quiet = 1'b0;

		// The machine can stop only once per reset, so the closing part takes either a halt
		// or an unknown opcode, then shows that execution is frozen and memory still works.
		if ($urandom_range(1))
			put_insn(OP_HLT, 8'($urandom()), 8'($urandom()), $urandom());
		else if ($urandom_range(1))
			put_insn(8'h00, 8'($urandom()), 8'($urandom()), $urandom());
		else
			put_insn(8'($urandom_range(17, 255)), 8'($urandom()), 8'($urandom()), $urandom());
		exec_at_pc(1'b1, 1'b0);
		exec_at_pc(1'b1, 1'b0);
		put_byte(16'h4321, 8'h3c);
		it = '{mode: MODE_READ, mem_addr: 16'h4321, mem_data: 8'h00};
		send(it);
		it = '{mode: MODE_NONE, mem_addr: 16'h0000, mem_data: 8'h00};
		send(it);
		start <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
design/trm_pkg.sv
design/trm_ram.sv
design/trm_div.sv
design/trm_datapath.sv
design/trm_ctrl.sv
design/toy_register_machine_step.sv
design/trm_checker.sv
sim/toy_register_machine_step_test.sv
